@@ sv/atr_pkg.sv @@
// shared types and constants of the antenna thrust acceleration core
// no dependencies
`default_nettype none

package atr_pkg;

  localparam int unsigned VECTOR_WIDTH = 40;
  localparam int unsigned DCM_W        = 20;
  localparam int unsigned MAG_W        = (VECTOR_WIDTH > 53) ? VECTOR_WIDTH : 53;
  localparam int unsigned BL_W         = $clog2(MAG_W + 1);
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [16:0] EFF_ONE     = 17'd65536;
  localparam logic [62:0] ACC_MAX     = '1;
  localparam logic [31:0] LIGHT_RESET = 32'd299792458;

  typedef enum logic [1:0] {
    MODE_VEL   = 2'd0,
    MODE_NADIR = 2'd1,
    MODE_FIXED = 2'd2,
    MODE_BODY  = 2'd3
  } dir_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 3'd0,
    CFG_FIX_X = 3'd1,
    CFG_FIX_Y = 3'd2,
    CFG_FIX_Z = 3'd3,
    CFG_POWER = 3'd4,
    CFG_EFF   = 3'd5,
    CFG_LIGHT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                            frame_is_inertial;
    logic [31:0]                     mass;
    logic signed [VECTOR_WIDTH-1:0]  state_vec_x;
    logic signed [VECTOR_WIDTH-1:0]  state_vec_y;
    logic signed [VECTOR_WIDTH-1:0]  state_vec_z;
    logic [59:0]                     dcm_row_0;
    logic [59:0]                     dcm_row_1;
    logic [59:0]                     dcm_row_2;
  } item_t;

  typedef struct packed {
    logic               status;
    logic signed [63:0] accel_x;
    logic signed [63:0] accel_y;
    logic signed [63:0] accel_z;
    logic [62:0]        thrust;
    logic [31:0]        effective_power;
    logic [31:0]        mass_echo;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } result_t;

endpackage

`default_nettype wire

@@ sv/antenna_thrust_acceleration_core.sv @@
// top level of the antenna radiation recoil thrust acceleration core
// uses atr_pkg, atr_div and atr_isqrt
`default_nettype none

// One spacecraft state enters per start pulse and one result leaves on
// done_o, for one cycle; the receiver cannot stall it.
// The core is fully pipelined: a new item can be started in every cycle,
// busy_o is only high while reset is applied and until busy_q is first clocked after it.
// The pipeline is made of the bit-serial stages: the 64-stage thrust
// divider, the 32-stage square root, the 31-stage direction dividers and
// the 63-stage acceleration dividers, plus ten register stages of input,
// multiply, select, normalize and output logic.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i with no
// wait states; it must only be changed while no item is in flight.
module antenna_thrust_acceleration_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  atr_pkg::item_t                item_i,
  output logic                          busy_o,
  output logic                          done_o,
  output atr_pkg::result_t              result_o,
  input  logic                          cfg_we_i,
  input  logic [atr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [atr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import atr_pkg::*;

  localparam int unsigned VW = VECTOR_WIDTH;

  // common sideband once the direction is normalized
  typedef struct packed {
    logic        inv;
    logic [2:0]  neg;
    logic [31:0] mass;
    logic [31:0] pe;
    logic [62:0] th;
  } sbc_t;

  // sideband through the thrust divider
  typedef struct packed {
    logic                      inv;
    logic [2:0]                neg;
    logic [2:0][MAG_W-1:0]     mag;
    logic [31:0]               mass;
    logic [31:0]               pe;
  } sb3_t;

  typedef struct packed {
    sbc_t            c;
    logic [2:0][30:0] mag;
  } sb7_t;

  typedef struct packed {
    logic            over;
    sbc_t            c;
    logic [2:0][30:0] d;
  } sba_t;

  // configuration registers
  dir_mode_e          mode_q;
  logic signed [31:0] fix_q [3];
  logic [31:0]        power_q;
  logic [16:0]        eff_q;
  logic [31:0]        light_q;
  logic               busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_VEL;
      fix_q[0] <= '0;
      fix_q[1] <= '0;
      fix_q[2] <= '0;
      power_q  <= '0;
      eff_q    <= EFF_ONE;
      light_q  <= LIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:  mode_q   <= dir_mode_e'(cfg_data_i[1:0]);
        CFG_FIX_X: fix_q[0] <= cfg_data_i;
        CFG_FIX_Y: fix_q[1] <= cfg_data_i;
        CFG_FIX_Z: fix_q[2] <= cfg_data_i;
        CFG_POWER: power_q  <= cfg_data_i;
        CFG_EFF:   eff_q    <= cfg_data_i[16:0];
        CFG_LIGHT: light_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // busy in reset and until first clocked after it, then the pipeline takes an item every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end
  assign busy_o = busy_q;

  // stage 1: input register
  logic  s1_vld_q;
  item_t s1_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s1_item_q <= item_i;
  end

  // stage 2: matrix products for body axis mode, power times efficiency, checks
  logic              s2_vld_q;
  logic              s2_inv_q, s2_inv_d;
  logic [VW-1:0]     s2_vec_q [3];
  logic [31:0]       s2_mass_q;
  logic signed [51:0] s2_prod_q [3][3];
  logic signed [51:0] s2_prod_d [3][3];
  logic [48:0]       s2_pep_q;
  logic [59:0]       row [3];

  assign row[0] = s1_item_q.dcm_row_0;
  assign row[1] = s1_item_q.dcm_row_1;
  assign row[2] = s1_item_q.dcm_row_2;

  // component i of the transposed matrix times the axis: sum over row j
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s2_prod_d[i][j] = 52'($signed(row[j][DCM_W*i +: DCM_W]) * fix_q[j]);
      end
    end
  end

  assign s2_inv_d = !s1_item_q.frame_is_inertial || (s1_item_q.mass == '0) ||
                    (light_q == '0) || (eff_q > EFF_ONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s2_inv_q    <= s2_inv_d;
    s2_vec_q[0] <= s1_item_q.state_vec_x;
    s2_vec_q[1] <= s1_item_q.state_vec_y;
    s2_vec_q[2] <= s1_item_q.state_vec_z;
    s2_mass_q   <= s1_item_q.mass;
    s2_prod_q   <= s2_prod_d;
    s2_pep_q    <= power_q * eff_q;
  end

  // stage 3: pick the direction vector by mode, split into sign and magnitude
  logic  s3_vld_q;
  sb3_t  s3_sb_q, s3_sb_d;

  always_comb begin
    logic [VW-1:0]     vu;
    logic [VW-1:0]     vm;
    logic [31:0]       fu;
    logic [31:0]       fm;
    logic signed [53:0] bs;
    logic [53:0]       bu;
    s3_sb_d      = '0;
    s3_sb_d.mass = s2_mass_q;
    s3_sb_d.pe   = s2_pep_q[47:16];
    for (int i = 0; i < 3; i++) begin
      vu = s2_vec_q[i];
      fu = fix_q[i];
      // negate at the field width before widening
      vm = vu[VW-1] ? (~vu + 1'b1) : vu;
      fm = fu[31] ? (~fu + 1'b1) : fu;
      bs = 54'(s2_prod_q[i][0]) + 54'(s2_prod_q[i][1]) + 54'(s2_prod_q[i][2]);
      bu = bs;
      unique case (mode_q) inside
        MODE_VEL, MODE_NADIR: begin
          s3_sb_d.mag[i] = MAG_W'(vm);
          s3_sb_d.neg[i] = vu[VW-1] ^ (mode_q == MODE_NADIR);
        end
        MODE_FIXED: begin
          s3_sb_d.mag[i] = MAG_W'(fm);
          s3_sb_d.neg[i] = fu[31];
        end
        default: begin
          s3_sb_d.mag[i] = MAG_W'(bu[53] ? (~bu + 1'b1) : bu);
          s3_sb_d.neg[i] = bu[53];
        end
      endcase
    end
    // zero vector has no direction
    s3_sb_d.inv = s2_inv_q || (s3_sb_d.mag == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s3_sb_q <= s3_sb_d;
  end

  // thrust = effective power * 2^32 / light speed
  logic        t_vld;
  logic [63:0] t_quo;
  sb3_t        t_sb;

  atr_div #(
    .DenW (32),
    .QuoW (64),
    .SideW($bits(sb3_t))
  ) u_thrust_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (s3_vld_q),
    .rem_i ('0),
    .num_i ({s3_sb_q.pe, 32'd0}),
    .den_i (light_q),
    .side_i(s3_sb_q),
    .vld_o (t_vld),
    .quo_o (t_quo),
    .side_o(t_sb)
  );

  // stage 4: saturate thrust, bit length of the largest magnitude
  logic            s4_vld_q;
  sb3_t            s4_sb_q;
  logic [62:0]     s4_th_q;
  logic [BL_W-1:0] s4_bl_q, s4_bl_d;

  always_comb begin
    logic [MAG_W-1:0] mx;
    mx = t_sb.mag[0];
    if (t_sb.mag[1] > mx) mx = t_sb.mag[1];
    if (t_sb.mag[2] > mx) mx = t_sb.mag[2];
    s4_bl_d = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (mx[k]) s4_bl_d = BL_W'(k + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= t_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    s4_sb_q <= t_sb;
    s4_th_q <= t_quo[63] ? ACC_MAX : t_quo[62:0];
    s4_bl_q <= s4_bl_d;
  end

  // stage 5: bring the largest magnitude into [2^30, 2^31)
  logic             s5_vld_q;
  sbc_t             s5_c_q;
  logic [2:0][30:0] s5_mag_q, s5_mag_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s4_bl_q > BL_W'(31)) begin
        s5_mag_d[i] = 31'(s4_sb_q.mag[i] >> (s4_bl_q - BL_W'(31)));
      end else begin
        s5_mag_d[i] = 31'(s4_sb_q.mag[i] << (BL_W'(31) - s4_bl_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s5_mag_q    <= s5_mag_d;
    s5_c_q.inv  <= s4_sb_q.inv;
    s5_c_q.neg  <= s4_sb_q.neg;
    s5_c_q.mass <= s4_sb_q.mass;
    s5_c_q.pe   <= s4_sb_q.pe;
    s5_c_q.th   <= s4_th_q;
  end

  // stage 6: squares, stage 7: sum of squares
  logic             s6_vld_q;
  sbc_t             s6_c_q;
  logic [2:0][30:0] s6_mag_q;
  logic [61:0]      s6_sq_q [3];
  logic             s7_vld_q;
  sb7_t             s7_sb_q;
  logic [63:0]      s7_ss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    s6_c_q   <= s5_c_q;
    s6_mag_q <= s5_mag_q;
    for (int i = 0; i < 3; i++) begin
      s6_sq_q[i] <= s5_mag_q[i] * s5_mag_q[i];
    end
    s7_sb_q.c   <= s6_c_q;
    s7_sb_q.mag <= s6_mag_q;
    s7_ss_q     <= 64'(s6_sq_q[0]) + 64'(s6_sq_q[1]) + 64'(s6_sq_q[2]);
  end

  // norm of the scaled vector
  logic        q_vld;
  logic [31:0] q_root;
  sb7_t        q_sb;

  atr_isqrt #(
    .SideW($bits(sb7_t))
  ) u_norm_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (s7_vld_q),
    .rad_i (s7_ss_q),
    .side_i(s7_sb_q),
    .vld_o (q_vld),
    .root_o(q_root),
    .side_o(q_sb)
  );

  // unit direction = magnitude * 2^30 / norm; norm is at least 2^30 so the
  // upper dividend bits can preload the remainder
  logic        dv_vld;
  logic [30:0] dq [3];
  logic [3:0]  dv_flags;
  logic [63:0] dv_mpe;
  logic [62:0] dv_th;

  atr_div #(
    .DenW (32),
    .QuoW (31),
    .SideW(4)
  ) u_dir_div_x (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (q_vld),
    .rem_i ({2'b00, q_sb.mag[0][30:1]}),
    .num_i ({q_sb.mag[0][0], 30'd0}),
    .den_i (q_root),
    .side_i({q_sb.c.inv, q_sb.c.neg}),
    .vld_o (dv_vld),
    .quo_o (dq[0]),
    .side_o(dv_flags)
  );

  atr_div #(
    .DenW (32),
    .QuoW (31),
    .SideW(64)
  ) u_dir_div_y (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (q_vld),
    .rem_i ({2'b00, q_sb.mag[1][30:1]}),
    .num_i ({q_sb.mag[1][0], 30'd0}),
    .den_i (q_root),
    .side_i({q_sb.c.mass, q_sb.c.pe}),
    .vld_o (),
    .quo_o (dq[1]),
    .side_o(dv_mpe)
  );

  atr_div #(
    .DenW (32),
    .QuoW (31),
    .SideW(63)
  ) u_dir_div_z (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (q_vld),
    .rem_i ({2'b00, q_sb.mag[2][30:1]}),
    .num_i ({q_sb.mag[2][0], 30'd0}),
    .den_i (q_root),
    .side_i(q_sb.c.th),
    .vld_o (),
    .quo_o (dq[2]),
    .side_o(dv_th)
  );

  // stage m1: thrust times direction as two partial products
  logic             m1_vld_q;
  sbc_t             m1_c_q;
  logic [2:0][30:0] m1_d_q;
  logic [62:0]      m1_plo_q [3];
  logic [61:0]      m1_phi_q [3];
  // stage m2: full product
  logic             m2_vld_q;
  sbc_t             m2_c_q;
  logic [2:0][30:0] m2_d_q;
  logic [93:0]      m2_p_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
    end else begin
      m1_vld_q <= dv_vld;
      m2_vld_q <= m1_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    m1_c_q.inv  <= dv_flags[3];
    m1_c_q.neg  <= dv_flags[2:0];
    m1_c_q.mass <= dv_mpe[63:32];
    m1_c_q.pe   <= dv_mpe[31:0];
    m1_c_q.th   <= dv_th;
    for (int i = 0; i < 3; i++) begin
      m1_d_q[i]   <= dq[i];
      m1_plo_q[i] <= dv_th[31:0] * dq[i];
      m1_phi_q[i] <= dv_th[62:32] * dq[i];
    end
    m2_c_q <= m1_c_q;
    m2_d_q <= m1_d_q;
    for (int i = 0; i < 3; i++) begin
      m2_p_q[i] <= {m1_phi_q[i], 32'd0} + 94'(m1_plo_q[i]);
    end
  end

  // acceleration = product / (mass * 64); quotient of 2^63 or more saturates,
  // which is exactly the case where the top product bits reach the divisor
  logic [37:0] a_den;
  logic [2:0]  a_over;
  sba_t        a_sb_in, a_sb;
  logic        a_vld;
  logic [62:0] aq [3];
  logic        a_over_y, a_over_z;

  assign a_den = {m2_c_q.mass, 6'd0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_over[i] = (38'(m2_p_q[i][93:63]) >= a_den);
    end
    a_sb_in.over = a_over[0];
    a_sb_in.c    = m2_c_q;
    a_sb_in.d    = m2_d_q;
  end

  atr_div #(
    .DenW (38),
    .QuoW (63),
    .SideW($bits(sba_t))
  ) u_acc_div_x (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (m2_vld_q),
    .rem_i (38'(m2_p_q[0][93:63])),
    .num_i (m2_p_q[0][62:0]),
    .den_i (a_den),
    .side_i(a_sb_in),
    .vld_o (a_vld),
    .quo_o (aq[0]),
    .side_o(a_sb)
  );

  atr_div #(
    .DenW (38),
    .QuoW (63),
    .SideW(1)
  ) u_acc_div_y (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (m2_vld_q),
    .rem_i (38'(m2_p_q[1][93:63])),
    .num_i (m2_p_q[1][62:0]),
    .den_i (a_den),
    .side_i(a_over[1]),
    .vld_o (),
    .quo_o (aq[1]),
    .side_o(a_over_y)
  );

  atr_div #(
    .DenW (38),
    .QuoW (63),
    .SideW(1)
  ) u_acc_div_z (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (m2_vld_q),
    .rem_i (38'(m2_p_q[2][93:63])),
    .num_i (m2_p_q[2][62:0]),
    .den_i (a_den),
    .side_i(a_over[2]),
    .vld_o (),
    .quo_o (aq[2]),
    .side_o(a_over_z)
  );

  // output stage: apply signs and saturation; when invalid, set status and zero all else
  logic    done_q;
  result_t result_q, result_d;

  always_comb begin
    logic [2:0]  ov;
    logic [63:0] acc [3];
    logic [31:0] dr  [3];
    logic [63:0] a64;
    logic [31:0] d32;
    ov = {a_over_z, a_over_y, a_sb.over};
    for (int i = 0; i < 3; i++) begin
      a64    = {1'b0, (ov[i] ? ACC_MAX : aq[i])};
      d32    = {1'b0, a_sb.d[i]};
      acc[i] = a_sb.c.neg[i] ? (~a64 + 64'd1) : a64;
      dr[i]  = a_sb.c.neg[i] ? (~d32 + 32'd1) : d32;
    end
    result_d = '0;
    if (a_sb.c.inv) begin
      result_d.status = 1'b1;
    end else begin
      result_d.accel_x         = acc[0];
      result_d.accel_y         = acc[1];
      result_d.accel_z         = acc[2];
      result_d.thrust          = a_sb.c.th;
      result_d.effective_power = a_sb.c.pe;
      result_d.mass_echo       = a_sb.c.mass;
      result_d.dir_x           = dr[0];
      result_d.dir_y           = dr[1];
      result_d.dir_z           = dr[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= a_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

@@ sv/atr_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with sideband
// standalone, no package needed
`default_nettype none

module atr_div #(
  parameter int unsigned DenW  = 32,
  parameter int unsigned QuoW  = 64,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [DenW-1:0]  rem_i,
  input  logic [QuoW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [QuoW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic [QuoW-1:0]  vld_q;
  logic [DenW-1:0]  rem_q  [QuoW];
  logic [DenW-1:0]  rem_d  [QuoW];
  logic [QuoW-1:0]  nq_q   [QuoW];
  logic [QuoW-1:0]  nq_d   [QuoW];
  logic [DenW-1:0]  den_q  [QuoW];
  logic [SideW-1:0] side_q [QuoW];

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    logic [DenW-1:0] pr;
    logic [DenW-1:0] pd;
    logic [QuoW-1:0] pn;
    logic [DenW:0]   t;
    logic [DenW:0]   diff;
    logic            ge;
    for (int k = 0; k < QuoW; k++) begin
      if (k == 0) begin
        pr = rem_i;
        pn = num_i;
        pd = den_i;
      end else begin
        pr = rem_q[k-1];
        pn = nq_q[k-1];
        pd = den_q[k-1];
      end
      t        = {pr, pn[QuoW-1]};
      diff     = t - {1'b0, pd};
      ge       = (t >= {1'b0, pd});
      rem_d[k] = ge ? diff[DenW-1:0] : t[DenW-1:0];
      nq_d[k]  = {pn[QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QuoW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    nq_q      <= nq_d;
    den_q[0]  <= den_i;
    side_q[0] <= side_i;
    for (int k = 1; k < QuoW; k++) begin
      den_q[k]  <= den_q[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  assign vld_o  = vld_q[QuoW-1];
  assign quo_o  = nq_q[QuoW-1];
  assign side_o = side_q[QuoW-1];

endmodule

`default_nettype wire

@@ sv/atr_isqrt.sv @@
// pipelined 64-bit integer square root, one result bit per stage, with sideband
// standalone, no package needed
`default_nettype none

module atr_isqrt #(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [63:0]      rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [31:0]      root_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned Steps = 32;

  logic [Steps-1:0] vld_q;
  logic [63:0]      x_q    [Steps];
  logic [63:0]      x_d    [Steps];
  logic [63:0]      r_q    [Steps];
  logic [63:0]      r_d    [Steps];
  logic [SideW-1:0] side_q [Steps];

  always_comb begin
    logic [63:0] px;
    logic [63:0] pr;
    logic [63:0] b;
    logic [63:0] s;
    for (int k = 0; k < Steps; k++) begin
      if (k == 0) begin
        px = rad_i;
        pr = '0;
      end else begin
        px = x_q[k-1];
        pr = r_q[k-1];
      end
      b = 64'd1 << (62 - 2 * k);
      s = pr + b;
      if (px >= s) begin
        x_d[k] = px - s;
        r_d[k] = (pr >> 1) + b;
      end else begin
        x_d[k] = px;
        r_d[k] = pr >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Steps-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    r_q       <= r_d;
    side_q[0] <= side_i;
    for (int k = 1; k < Steps; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign root_o = r_q[Steps-1][31:0];
  assign side_o = side_q[Steps-1];

endmodule

`default_nettype wire
